[design/mphs_pkg.sv]
package mphs_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int KEY_BYTES       = 4;

  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 11;
  localparam int COUNT_W = 11;
  localparam int OP_W    = 2;

  localparam logic [SLOT_W-1:0] SLOTS_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [31:0] SEED_BASE = 32'h5381_55AA;
  localparam logic [31:0] MM_C1     = 32'hcc9e_2d51;
  localparam logic [31:0] MM_C2     = 32'h1b87_3593;
  localparam logic [31:0] MM_N      = 32'he654_6b64;
  localparam logic [31:0] MM_F1     = 32'h85eb_ca6b;
  localparam logic [31:0] MM_F2     = 32'hc2b2_ae35;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 4) ? 32'hFFFF_FFFF : 32'((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  // remainder unit: bits retired per cycle and steps per 32-bit hash
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = 32 / MOD_BITS;
  localparam int MOD_CW    = $clog2(MOD_STEPS);

  // key word plus busy flag in the top bit
  localparam int ENTRY_W = KEY_W + 1;

  function automatic logic [31:0] mphs_rotl(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] mphs_body(input logic [31:0] h);
    logic [31:0] t;
    t = mphs_rotl(h, 13);
    return (t << 2) + t + MM_N;
  endfunction

  // Block and tail rounds plus the first fold of the finalizer. Bytes above
  // the 32-bit key are zero, so their mixed value is zero as well.
  function automatic logic [31:0] mphs_pre(input logic [31:0] seed,
                                           input logic [31:0] kmix);
    logic [31:0] h;
    h = seed ^ kmix;
    if (KEY_BYTES >= 4) begin
      h = mphs_body(h);
    end
    if (KEY_BYTES >= 8) begin
      h = mphs_body(h);
    end
    h = h ^ 32'(KEY_BYTES);
    return h ^ (h >> 16);
  endfunction

endpackage

[design/mphs_ram.sv]
module mphs_ram #(
  parameter int WIDTH = mphs_pkg::ENTRY_W,
  parameter int DEPTH = mphs_pkg::DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/murmur3_probed_hash_set_top.sv]
// A request refused up front (opcode 3, load limit, empty set) goes from ST_IDLE
// straight to ST_DONE; otherwise it runs ST_MIX1 and ST_MIX2, then p probes.
// Each probe runs ST_PRE, then ST_FM1 and ST_FM2 on one shared 32x32 multiplier,
// MOD_STEPS remainder steps at 4 bits each, one table read and one compare/write.
// One request at a time: in_tready only in ST_IDLE; ST_DONE waits on out_tready.
// Reset: a clearing pass frees every slot; takes config.
module murmur3_probed_hash_set_top #(
  parameter int TABLE_DEPTH = mphs_pkg::DEF_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config: table_slots
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mphs_pkg::SLOT_W-1:0]   cfg_data,
  // request
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] key
  input  logic [1:0]                    in_tuser,   // [1:0] opcode
  // result
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata   // [0] ok, [11:1] count
);

  import mphs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_MIX1  = 11'b000_0000_0100,
    ST_MIX2  = 11'b000_0000_1000,
    ST_PRE   = 11'b000_0001_0000,
    ST_FM1   = 11'b000_0010_0000,
    ST_FM2   = 11'b000_0100_0000,
    ST_MOD   = 11'b000_1000_0000,
    ST_RD    = 11'b001_0000_0000,
    ST_CMP   = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0]    cfg_slots_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [31:0]          kmix_r, kmix_nxt;
  logic [31:0]          h_r, h_nxt;
  logic [SLOT_W-1:0]    rem_r, rem_nxt;
  logic [MOD_CW-1:0]    mod_cnt_r, mod_cnt_nxt;
  logic [SLOT_W:0]      k_r, k_nxt;
  logic [31:0]          sq_r, sq_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic [SLOT_W-1:0]    slots;
  logic                 load_full;
  logic [31:0]          mul_a, mul_b, prod;
  logic [SLOT_W-1:0]    mod_rem;
  logic [SLOT_W:0]      mod_t;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic                 rd_busy, rd_match;
  logic                 in_xfer, out_load;

  // slot count in use: zero acts as one, clamp to the table depth
  always_comb begin
    slots = cfg_slots_r;
    if (cfg_slots_r == '0) begin
      slots = SLOT_W'(1);
    end else if (32'(cfg_slots_r) > 32'(TABLE_DEPTH)) begin
      slots = SLOT_W'(TABLE_DEPTH);
    end
  end

  assign load_full = (15'(count_r) * 15'd10) >= (15'(slots) * 15'd7);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_slots_r <= SLOTS_RESET;
    end else if (cfg_valid) begin
      cfg_slots_r <= cfg_data;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = h_r;
    mul_b = MM_F1;
    case (state_r)
      ST_MIX1: begin
        mul_a = key_r & KEY_MASK;
        mul_b = MM_C1;
      end
      ST_MIX2: begin
        mul_a = mphs_rotl(kmix_r, 15);
        mul_b = MM_C2;
      end
      ST_FM2: begin
        mul_b = MM_F2;
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // restoring remainder, MOD_BITS hash bits per cycle
  always_comb begin
    mod_rem = rem_r;
    mod_t   = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      mod_t = {mod_rem, h_r[31-i]};
      if (mod_t >= {1'b0, slots}) begin
        mod_t = mod_t - {1'b0, slots};
      end
      mod_rem = mod_t[SLOT_W-1:0];
    end
  end

  assign rd_busy  = ram_rdata[ENTRY_W-1];
  assign rd_match = ((ram_rdata[KEY_W-1:0] ^ key_r) & KEY_MASK) == '0;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    kmix_nxt      = kmix_r;
    h_nxt         = h_r;
    rem_nxt       = rem_r;
    mod_cnt_nxt   = mod_cnt_r;
    k_nxt         = k_r;
    sq_nxt        = sq_r;
    ok_nxt        = ok_r;
    ram_we        = 1'b0;
    ram_addr      = AW'(rem_r);
    ram_wdata     = {1'b1, key_r & KEY_MASK};

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt  = in_tuser;
          key_nxt = in_tdata;
          k_nxt   = '0;
          sq_nxt  = '0;
          ok_nxt  = 1'b0;
          // refuse without probing
          if ((in_tuser == OP_NONE) ||
              ((in_tuser == OP_ADD) && load_full) ||
              ((in_tuser != OP_ADD) && (count_r == '0))) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MIX1;
          end
        end
      end
      ST_MIX1: begin
        kmix_nxt  = prod;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        kmix_nxt  = prod;
        state_nxt = ST_PRE;
      end
      ST_PRE: begin
        h_nxt     = mphs_pre(SEED_BASE + sq_r, kmix_r);
        state_nxt = ST_FM1;
      end
      ST_FM1: begin
        h_nxt     = prod ^ (prod >> 13);
        state_nxt = ST_FM2;
      end
      ST_FM2: begin
        h_nxt       = prod ^ (prod >> 16);
        rem_nxt     = '0;
        mod_cnt_nxt = '0;
        state_nxt   = ST_MOD;
      end
      ST_MOD: begin
        rem_nxt     = mod_rem;
        h_nxt       = h_r << MOD_BITS;
        mod_cnt_nxt = mod_cnt_r + MOD_CW'(1);
        if (mod_cnt_r == MOD_CW'(MOD_STEPS - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!rd_busy) begin
          // free slot ends the probe
          if (op_r == OP_ADD) begin
            ram_we    = 1'b1;
            count_nxt = count_r + COUNT_W'(1);
            ok_nxt    = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (rd_match) begin
          if (op_r == OP_REMOVE) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, key_r & KEY_MASK};
            count_nxt = count_r - COUNT_W'(1);
          end
          ok_nxt    = (op_r != OP_ADD);
          state_nxt = ST_DONE;
        end else if (k_r == (SLOT_W + 1)'(slots)) begin
          state_nxt = ST_DONE;
        end else begin
          // next probe: seed offset advances by 2k+1
          k_nxt     = k_r + (SLOT_W + 1)'(1);
          sq_nxt    = sq_r + 32'({k_r, 1'b1});
          state_nxt = ST_PRE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_count_nxt = out_count_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok_r;
      out_count_nxt = count_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    kmix_r      <= kmix_nxt;
    h_r         <= h_nxt;
    rem_r       <= rem_nxt;
    mod_cnt_r   <= mod_cnt_nxt;
    k_r         <= k_nxt;
    sq_r        <= sq_nxt;
    ok_r        <= ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_count_r <= out_count_nxt;
  end

  mphs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_count_r, out_ok_r};

endmodule

[tb/sv/murmur3_probed_hash_set_top_test.sv]
module murmur3_probed_hash_set_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mphs_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } set_reply_t;

  typedef enum logic [1:0] {PROBE_FREE, PROBE_HIT, PROBE_EXHAUSTED} probe_end_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SLOT_W-1:0]  cfg_data = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;   // [31:0] key
  logic [1:0]         in_tuser = OP_ADD;   // [1:0] opcode
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;   // [0] ok, [11:1] count

  // shadow copy of the set
  logic [KEY_W-1:0]   slot_key [DEPTH];
  bit                 slot_used [DEPTH];
  int unsigned        keys_held = 0;
  logic [SLOT_W-1:0]  slots_cfg = SLOTS_RESET;
  logic [KEY_W-1:0]   insert_log [$];

  set_reply_t         pending_replies [$];
  int unsigned        requests_sent = 0;
  int unsigned        replies_seen = 0;
  int unsigned        errors = 0;
  bit                 quiet_mode = 1'b0;
  bit                 hold_off_req = 1'b0;

  murmur3_probed_hash_set_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur3_word(input logic [31:0] word,
                                               input logic [31:0] seed);
    logic [31:0] k;
    logic [31:0] h;
    k = word * MM_C1;
    k = rol32(k, 15);
    k = k * MM_C2;
    h = seed ^ k;
    h = rol32(h, 13);
    h = h * 32'd5 + MM_N;
    h = h ^ 32'(KEY_BYTES);
    h = h ^ (h >> 16);
    h = h * MM_F1;
    h = h ^ (h >> 13);
    h = h * MM_F2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic int unsigned active_slots();
    if (slots_cfg == '0) return 1;
    if (slots_cfg > DEPTH) return DEPTH;
    return int'(slots_cfg);
  endfunction

  function automatic probe_end_t probe_slots(input logic [KEY_W-1:0] key,
                                             output int unsigned slot);
    int unsigned s;
    s = active_slots();
    slot = 0;
    for (int unsigned k = 0; k <= s; k++) begin
      slot = murmur3_word(key, SEED_BASE + k * k) % s;
      if (!slot_used[slot]) return PROBE_FREE;
      if (((slot_key[slot] ^ key) & KEY_MASK) == '0) return PROBE_HIT;
    end
    return PROBE_EXHAUSTED;
  endfunction

  function automatic set_reply_t predict_reply(input logic [1:0] op,
                                               input logic [KEY_W-1:0] key);
    set_reply_t  r;
    int unsigned slot;
    r.ok = 1'b0;
    case (op)
      OP_ADD: begin
        if (10 * keys_held < 7 * active_slots() &&
            probe_slots(key, slot) == PROBE_FREE) begin
          slot_key[slot] = key & KEY_MASK;
          slot_used[slot] = 1'b1;
          keys_held++;
          insert_log.push_back(key & KEY_MASK);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (keys_held != 0 && probe_slots(key, slot) == PROBE_HIT) begin
          slot_used[slot] = 1'b0;
          keys_held--;
          foreach (insert_log[i]) begin
            if (insert_log[i] == (key & KEY_MASK)) begin
              insert_log.delete(i);
              break;
            end
          end
          r.ok = 1'b1;
        end
      end
      OP_TEST: begin
        if (keys_held != 0 && probe_slots(key, slot) == PROBE_HIT) r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = keys_held[COUNT_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Check replies first, then take config and requests, all on pre-edge values.
  always @(posedge clk) begin : monitor
    set_reply_t want;
    logic       got_ok;
    logic [COUNT_W-1:0] got_count;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_ok = out_tdata[0];
        got_count = out_tdata[COUNT_W:1];
        replies_seen++;
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t: reply with none pending: ok=%0d count=%0d",
                   $time, got_ok, got_count);
        end else begin
          want = pending_replies.pop_front();
          if (got_ok !== want.ok) begin
            errors++;
            $display("%0t: ok mismatch: expected %0d, actual %0d",
                     $time, want.ok, got_ok);
          end
          if (got_count !== want.count) begin
            errors++;
            $display("%0t: count mismatch: expected %0d, actual %0d",
                     $time, want.count, got_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) slots_cfg = cfg_data;
      if (in_tvalid && in_tready) pending_replies.push_back(predict_reply(in_tuser, in_tdata));
    end
  end

  initial begin : result_sink
    int unsigned run;
    int unsigned gap;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_tready <= 1'b1;
      run = quiet_mode ? 1 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = quiet_mode ? 0 : pick_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Leaves tvalid high after the transfer; wait_for_replies, or a next call with a gap, drops it.
  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    while (replies_seen != requests_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slots(input logic [SLOT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Remove newest keys first so no removal strands a key behind a freed slot.
  task automatic clear_set();
    logic [KEY_W-1:0] order [$];
    order = insert_log;
    for (int i = order.size() - 1; i >= 0; i--) send_request(OP_REMOVE, order[i]);
    wait_for_replies();
  endtask

  function automatic logic [KEY_W-1:0] find_unplaceable_key();
    logic [KEY_W-1:0] cand;
    int unsigned      slot;
    cand = $urandom();
    while (probe_slots(cand, slot) != PROBE_EXHAUSTED) cand++;
    return cand;
  endfunction

  task automatic test_empty_set();
    write_slots(SLOTS_RESET);
    send_request(OP_TEST, 32'h0000_0000);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OP_NONE, 32'h0000_0000);
    wait_for_replies();
  endtask

  task automatic test_add_remove();
    send_request(OP_ADD, 32'h0000_0000);
    send_request(OP_ADD, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'h0000_0000);
    send_request(OP_TEST, 32'h0000_0000);
    send_request(OP_TEST, 32'hFFFF_FFFF);
    send_request(OP_TEST, 32'h1234_5678);
    send_request(OP_NONE, 32'hA5A5_A5A5);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_TEST, 32'h0000_0000);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    wait_for_replies();
  endtask

  // One slot holds one key before the load limit; zero acts as one, above
  // the depth acts as the depth.
  task automatic test_slot_count_limits();
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] k2;
    k1 = $urandom();
    k2 = ~k1;
    write_slots(11'd1);
    send_request(OP_ADD, k1);
    send_request(OP_ADD, k2);
    send_request(OP_TEST, k1);
    send_request(OP_REMOVE, k1);
    wait_for_replies();
    write_slots(11'd0);
    send_request(OP_ADD, k2);
    send_request(OP_TEST, k2);
    send_request(OP_REMOVE, k2);
    wait_for_replies();
    write_slots(11'h7FF);
    send_request(OP_ADD, k1);
    send_request(OP_TEST, k1);
    send_request(OP_REMOVE, k1);
    wait_for_replies();
  endtask

  // Every probe of the new key lands on the one busy slot, so the add is refused.
  task automatic test_probe_exhaustion();
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] blocked;
    k1 = $urandom();
    write_slots(11'd2);
    send_request(OP_ADD, k1);
    wait_for_replies();
    blocked = find_unplaceable_key();
    send_request(OP_ADD, blocked);
    send_request(OP_TEST, blocked);
    send_request(OP_REMOVE, blocked);
    send_request(OP_REMOVE, k1);
    wait_for_replies();
  endtask

  // Keys stay put and counted when the slot count drops under them.
  task automatic test_shrink_with_keys();
    logic [KEY_W-1:0] keys [6];
    write_slots(11'd16);
    foreach (keys[i]) begin
      keys[i] = $urandom();
      send_request(OP_ADD, keys[i]);
    end
    wait_for_replies();
    write_slots(11'd2);
    foreach (keys[i]) send_request(OP_TEST, keys[i]);
    send_request(OP_ADD, $urandom());
    send_request(OP_REMOVE, keys[0]);
    send_request(OP_REMOVE, keys[1]);
    wait_for_replies();
    write_slots(11'd16);
    clear_set();
  endtask

  // Hold the result side long enough that the request side backs up.
  task automatic test_result_backpressure();
    logic [KEY_W-1:0] keys [8];
    write_slots(SLOTS_RESET);
    hold_off_req = 1'b1;
    foreach (keys[i]) begin
      keys[i] = $urandom();
      send_request(OP_ADD, keys[i]);
    end
    foreach (keys[i]) send_request(OP_TEST, keys[i]);
    wait_for_replies();
    clear_set();
  endtask

  task automatic run_random_phase(input logic [SLOT_W-1:0] slots,
                                  input int unsigned n_items,
                                  input int unsigned pool_size,
                                  input int unsigned add_pct);
    logic [KEY_W-1:0] pool [$];
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    int unsigned      roll;
    write_slots(slots);
    pool.push_back(32'h0000_0000);
    pool.push_back(32'hFFFF_FFFF);
    repeat (pool_size) pool.push_back($urandom());
    for (int unsigned i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_NONE;
      else if (roll < 3 + add_pct) op = OP_ADD;
      else if (roll < 3 + add_pct + (97 - add_pct) / 2) op = OP_TEST;
      else op = OP_REMOVE;
      if ($urandom_range(0, 3) == 0) key = $urandom();
      else key = pool[$urandom_range(0, pool.size() - 1)];
      send_request(op, key);
      if ($urandom_range(0, 99) == 0) wait_for_replies();
    end
    wait_for_replies();
    clear_set();
  endtask

  task automatic test_random_traffic();
    run_random_phase(11'd2, 120, 4, 45);
    run_random_phase(11'd3, 120, 6, 45);
    quiet_mode = 1'b1;
    run_random_phase(11'd7, 150, 10, 45);
    quiet_mode = 1'b0;
    run_random_phase(11'd64, 300, 80, 65);
    run_random_phase(SLOTS_RESET, 300, 200, 50);
    run_random_phase(11'($urandom_range(512, 2047)), 200, 150, 50);
    run_random_phase(11'($urandom_range(1, 40)), 100, 20, 50);
  endtask

  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_set();
    test_add_remove();
    test_slot_count_limits();
    test_probe_exhaustion();
    test_shrink_with_keys();
    test_result_backpressure();
    test_random_traffic();
    wait_for_replies();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("%0t: timeout", $time);
    $display("tb: failure");
    $finish;
  end

endmodule

[murmur3_probed_hash_set_top.f]
design/mphs_pkg.sv
design/mphs_ram.sv
design/murmur3_probed_hash_set_top.sv
tb/sv/murmur3_probed_hash_set_top_test.sv
